>>> hw/rtl/prrlt_pkg.sv
// ----------------------------------------------------------------------------
// Region lookup table package
// Shared codes, field layout and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package prrlt_pkg;

    // Operation selector, carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_CONTAIN   = 2'd0,
        FUNC_INTERSECT = 2'd1,
        FUNC_INSERT    = 2'd2,
        FUNC_DELETE    = 2'd3
    } func_t;

    // Result status, carried on m_tuser
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam int FUNC_W  = 2;
    localparam int RANK_W  = 4;
    localparam int FIELD_W = 48;
    localparam int TAG_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;

    // Input tdata layout
    localparam int S_RANK_LSB  = 0;
    localparam int S_START_LSB = S_RANK_LSB + RANK_W;
    localparam int S_LEN_LSB   = S_START_LSB + FIELD_W;
    localparam int S_TAG_LSB   = S_LEN_LSB + FIELD_W;
    localparam int S_USED_W    = S_TAG_LSB + TAG_W;
    localparam int S_DATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int M_START_LSB = 0;
    localparam int M_LEN_LSB   = M_START_LSB + FIELD_W;
    localparam int M_TAG_LSB   = M_LEN_LSB + FIELD_W;
    localparam int M_SLOT_LSB  = M_TAG_LSB + TAG_W;
    localparam int M_USED_W    = M_SLOT_LSB + SLOT_W;
    localparam int M_DATA_W    = ((M_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic    clr_en;
        logic    capture;
        logic    scan_start;
        logic    shift_start;
        logic    step;
        logic    shift_wr;
        logic    hit_capture;
        logic    wr_new;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
        status_t out_status;
        logic    out_has;
    } prrlt_cmd_t;

    typedef struct packed {
        logic  clr_last;
        logic  rank_ok;
        logic  rd_more;
        logic  cmp_vld;
        logic  match;
        logic  cnt_full;
        logic  out_free;
        func_t func;
    } prrlt_sts_t;

endpackage

>>> hw/rtl/per_rank_region_lookup_table.sv
// ----------------------------------------------------------------------------
// Per-rank region lookup table
// Ordered tables of registered address regions, one per rank.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command per transfer on the s_ channel: s_tuser selects find
//   containing, find intersecting, insert or delete-by-start, and s_tdata
//   carries rank, start, length and tag. Each command yields exactly one
//   result transfer on the m_ channel: status on m_tuser, and the matched,
//   inserted, deleted or conflicting region with its slot on m_tdata.
//   Scan: the rank's entries are read one per cycle from the region
//   memory, in table order. A find stops at the first hit, a scan that
//   finds nothing reads every entry, and an empty rank reads none. An
//   insert adds a write of the new entry at the end of the rank; a delete
//   moves each later entry down one slot and then decrements the count.
//   One command is in work at a time. s_tready returns high as m_tvalid
//   rises. The result sits in an output register, so the next command is
//   accepted while the previous result waits; a stalled receiver holds
//   m_tdata steady and blocks only the hand-off of the following result.
//   Reset: s_tready stays low for NUM_RANKS cycles while the per-rank entry
//   counts are cleared, one rank per cycle.
// ----------------------------------------------------------------------------
module per_rank_region_lookup_table
    import prrlt_pkg::*;
#(
    parameter int NUM_RANKS        = 16,
    parameter int ENTRIES_PER_RANK = 16,
    parameter int ADDR_BITS        = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [FUNC_W-1:0]   s_tuser,   // func
    input  logic [S_DATA_W-1:0] s_tdata,   // rank, start_addr, length, region_tag
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STAT_W-1:0]   m_tuser,   // status
    output logic [M_DATA_W-1:0] m_tdata    // hit_start, hit_length, hit_tag, hit_slot
);

    prrlt_cmd_t cmd;
    prrlt_sts_t sts;

    prrlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    prrlt_dp #(
        .NUM_RANKS        (NUM_RANKS),
        .ENTRIES_PER_RANK (ENTRIES_PER_RANK),
        .ADDR_BITS        (ADDR_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hw/rtl/prrlt_ctrl.sv
// ----------------------------------------------------------------------------
// Region lookup table controller
// Sequences the count clear, table scan, insert, delete shift and result hand-off.
// ----------------------------------------------------------------------------
module prrlt_ctrl
    import prrlt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  prrlt_sts_t sts,
    output prrlt_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CNT   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_INS   = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    status_t res_status_reg, res_status_next;
    logic    res_has_reg, res_has_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            res_status_reg <= ST_MISS;
            res_has_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_has_reg    <= res_has_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_has_next    = res_has_reg;
        cmd             = '0;
        cmd.out_status  = res_status_reg;
        cmd.out_has     = res_has_reg;

        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CNT;
                end
            end
            S_CNT: begin
                // count read is in flight; rank range is already known
                if (!sts.rank_ok) begin
                    res_status_next = ST_MISS;
                    res_has_next    = 1'b0;
                    state_next      = S_RESP;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.match) begin
                    cmd.hit_capture = 1'b1;
                    res_has_next    = 1'b1;
                    priority case (sts.func)
                        FUNC_INSERT: begin
                            res_status_next = ST_OVERLAP;
                            state_next      = S_RESP;
                        end
                        FUNC_DELETE: begin
                            res_status_next = ST_OK;
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        default: begin
                            res_status_next = ST_OK;
                            state_next      = S_RESP;
                        end
                    endcase
                end else if (!sts.rd_more && !sts.cmp_vld) begin
                    res_has_next = 1'b0;
                    if (sts.func == FUNC_INSERT) begin
                        if (sts.cnt_full) begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end else begin
                            state_next = S_INS;
                        end
                    end else begin
                        res_status_next = ST_MISS;
                        state_next      = S_RESP;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                cmd.step     = 1'b1;
                cmd.shift_wr = 1'b1;
                if (!sts.rd_more && !sts.cmp_vld) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_INS: begin
                cmd.wr_new      = 1'b1;
                cmd.cnt_inc     = 1'b1;
                res_status_next = ST_OK;
                res_has_next    = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> hw/rtl/prrlt_dp.sv
// ----------------------------------------------------------------------------
// Region lookup table datapath
// Count and region memories, scan pointers, interval compare and output stage.
// ----------------------------------------------------------------------------
module prrlt_dp
    import prrlt_pkg::*;
#(
    parameter int NUM_RANKS        = 16,
    parameter int ENTRIES_PER_RANK = 16,
    parameter int ADDR_BITS        = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  prrlt_cmd_t          cmd,
    output prrlt_sts_t          sts,
    input  logic [FUNC_W-1:0]   s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STAT_W-1:0]   m_tuser,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int DEPTH = NUM_RANKS * ENTRIES_PER_RANK;
    localparam int MA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RK_W  = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
    localparam int CNT_W = $clog2(ENTRIES_PER_RANK + 1);

    // Item registers
    func_t             func_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              rank_ok_reg;
    logic [MA_W-1:0]   base_reg;
    logic [AW-1:0]     qs_reg, ql_reg;
    logic [TAG_W-1:0]  tag_reg;

    // Scan pointers
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg;
    logic [RK_W-1:0]   clr_idx_reg;

    // Memories and registered read data
    logic [CNT_W-1:0]  cnt_mem [NUM_RANKS];
    logic [AW-1:0]     start_mem [DEPTH];
    logic [AW-1:0]     len_mem [DEPTH];
    logic [TAG_W-1:0]  tag_mem [DEPTH];
    logic [CNT_W-1:0]  cnt_q;
    logic [AW-1:0]     rs_q, rl_q;
    logic [TAG_W-1:0]  rt_q;

    // Captured hit
    logic [AW-1:0]     hit_start_reg, hit_len_reg;
    logic [TAG_W-1:0]  hit_tag_reg;
    logic [CNT_W-1:0]  hit_slot_reg;

    // Output stage
    logic                m_tvalid_reg;
    logic [STAT_W-1:0]   m_tuser_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic              issue;
    logic [RK_W-1:0]   rank_idx;
    logic [MA_W-1:0]   rd_addr, wr_addr;
    logic              mem_we, cnt_we;
    logic [RK_W-1:0]   cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [AW-1:0]     wd_start, wd_len;
    logic [TAG_W-1:0]  wd_tag;
    logic [AW:0]       r_end, q_end;
    logic              covers, meets, same_start, hit;
    logic [RANK_W-1:0] s_rank;

    assign s_rank   = s_tdata[S_RANK_LSB +: RANK_W];
    assign rank_idx = RK_W'(rank_reg);
    assign issue    = cmd.step && (rd_idx_reg < cnt_q);
    assign rd_addr  = base_reg + MA_W'(rd_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= func_t'(s_tuser);
            rank_reg    <= s_rank;
            rank_ok_reg <= (32'(s_rank) < NUM_RANKS);
            base_reg    <= MA_W'(32'(s_rank) * ENTRIES_PER_RANK);
            qs_reg      <= AW'(s_tdata[S_START_LSB +: FIELD_W]);
            ql_reg      <= AW'(s_tdata[S_LEN_LSB +: FIELD_W]);
            tag_reg     <= s_tdata[S_TAG_LSB +: TAG_W];
        end
    end

    // Pointer control
    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.scan_start) begin
            rd_idx_next = '0;
        end else if (cmd.shift_start) begin
            rd_idx_next = cmp_idx_reg + CNT_W'(1);
        end else if (issue) begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            clr_idx_reg <= '0;
        end else begin
            cmp_vld_reg <= issue;
            if (cmd.clr_en) begin
                clr_idx_reg <= clr_idx_reg + RK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        if (issue) begin
            cmp_idx_reg <= rd_idx_reg;
        end
    end

    // Count memory: clearing pass after reset, then increment or decrement
    always_comb begin
        cnt_we    = cmd.clr_en | cmd.cnt_inc | cmd.cnt_dec;
        cnt_waddr = cmd.clr_en ? clr_idx_reg : rank_idx;
        if (cmd.clr_en) begin
            cnt_wdata = '0;
        end else if (cmd.cnt_inc) begin
            cnt_wdata = cnt_q + CNT_W'(1);
        end else begin
            cnt_wdata = cnt_q - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[rank_idx];
    end

    // Region memories: append at the fill point, or move an entry down one slot
    always_comb begin
        mem_we = cmd.wr_new | (cmd.shift_wr & cmp_vld_reg);
        if (cmd.wr_new) begin
            wr_addr  = base_reg + MA_W'(cnt_q);
            wd_start = qs_reg;
            wd_len   = ql_reg;
            wd_tag   = tag_reg;
        end else begin
            wr_addr  = base_reg + MA_W'(cmp_idx_reg) - MA_W'(1);
            wd_start = rs_q;
            wd_len   = rl_q;
            wd_tag   = rt_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            start_mem[wr_addr] <= wd_start;
            len_mem[wr_addr]   <= wd_len;
            tag_mem[wr_addr]   <= wd_tag;
        end
        if (issue) begin
            rs_q <= start_mem[rd_addr];
            rl_q <= len_mem[rd_addr];
            rt_q <= tag_mem[rd_addr];
        end
    end

    // Interval compare on inclusive ranges, end + 1 computed without wrap
    assign r_end      = {1'b0, rs_q} + {1'b0, rl_q};
    assign q_end      = {1'b0, qs_reg} + {1'b0, ql_reg};
    assign covers     = (rs_q <= qs_reg) && (q_end <= r_end);
    assign meets      = (r_end > {1'b0, qs_reg}) && (q_end > {1'b0, rs_q});
    assign same_start = (rs_q == qs_reg);

    always_comb begin
        unique case (func_reg)
            FUNC_CONTAIN:   hit = covers;
            FUNC_INTERSECT: hit = meets;
            FUNC_INSERT:    hit = covers | meets;
            FUNC_DELETE:    hit = same_start;
            default:        hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.hit_capture) begin
            hit_start_reg <= rs_q;
            hit_len_reg   <= rl_q;
            hit_tag_reg   <= rt_q;
            hit_slot_reg  <= cmp_idx_reg;
        end else if (cmd.wr_new) begin
            hit_start_reg <= qs_reg;
            hit_len_reg   <= ql_reg;
            hit_tag_reg   <= tag_reg;
            hit_slot_reg  <= cnt_q;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tuser_reg <= cmd.out_status;
            m_tdata_reg <= '0;
            if (cmd.out_has) begin
                m_tdata_reg[M_START_LSB +: FIELD_W] <= FIELD_W'(hit_start_reg);
                m_tdata_reg[M_LEN_LSB +: FIELD_W]   <= FIELD_W'(hit_len_reg);
                m_tdata_reg[M_TAG_LSB +: TAG_W]     <= hit_tag_reg;
                m_tdata_reg[M_SLOT_LSB +: SLOT_W]   <= SLOT_W'(hit_slot_reg);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts.clr_last = (clr_idx_reg == RK_W'(NUM_RANKS - 1));
        sts.rank_ok  = rank_ok_reg;
        sts.rd_more  = (rd_idx_reg < cnt_q);
        sts.cmp_vld  = cmp_vld_reg;
        sts.match    = cmp_vld_reg & hit;
        sts.cnt_full = (cnt_q >= CNT_W'(ENTRIES_PER_RANK));
        sts.out_free = !m_tvalid_reg || m_tready;
        sts.func     = func_reg;
    end

endmodule

>>> dv/per_rank_region_lookup_table_tb.sv
// ----------------------------------------------------------------------------
// Per-rank region lookup table testbench
// Drives find, insert and delete commands into the stream port and keeps its
// own copy of every rank's region table. Each result transfer is checked
// field by field against the predicted reply. The run covers directed edge
// cases, a full rank, long back-pressure and a random mix of commands.
// ----------------------------------------------------------------------------
module per_rank_region_lookup_table_tb;
    import prrlt_pkg::*;

    localparam int RANKS       = 16;
    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t     status;
        logic [47:0] start;
        logic [47:0] len;
        logic [31:0] tag;
        logic [3:0]  slot;
    } region_reply_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [FUNC_W-1:0]   s_tuser  = '0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [STAT_W-1:0]   m_tuser;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted table contents
    logic [47:0] tbl_start [RANKS][SLOTS];
    logic [47:0] tbl_len   [RANKS][SLOTS];
    logic [31:0] tbl_tag   [RANKS][SLOTS];
    int          tbl_count [RANKS];

    region_reply_t pending_replies[$];

    int mismatches = 0;
    int cycles     = 0;
    int rx_hold    = 0;
    bit steady     = 1'b0;
    int ops_sent    [4];
    int status_seen [4];

    per_rank_region_lookup_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Interval tests with the end sums kept one bit wider, so nothing wraps
    function automatic bit covers(logic [47:0] rs, logic [47:0] rl,
                                  logic [47:0] qs, logic [47:0] ql);
        return rs <= qs && ({1'b0, qs} + ql) <= ({1'b0, rs} + rl);
    endfunction

    function automatic bit meets(logic [47:0] rs, logic [47:0] rl,
                                 logic [47:0] qs, logic [47:0] ql);
        return ({1'b0, rs} + rl) > {1'b0, qs} && ({1'b0, qs} + ql) > {1'b0, rs};
    endfunction

    function automatic region_reply_t stored_reply(status_t st, int rk, int idx);
        region_reply_t r;
        r.status = st;
        r.start  = tbl_start[rk][idx];
        r.len    = tbl_len[rk][idx];
        r.tag    = tbl_tag[rk][idx];
        r.slot   = idx[3:0];
        return r;
    endfunction

    // Apply one command to the table copy and return the reply it must give
    function automatic region_reply_t apply_region_op(func_t f, logic [3:0] rk,
                                                      logic [47:0] qs, logic [47:0] ql,
                                                      logic [31:0] tg);
        region_reply_t r;
        int n;
        int hit;
        r        = '0;
        r.status = ST_MISS;
        n        = tbl_count[rk];
        hit      = -1;
        case (f)
            FUNC_CONTAIN, FUNC_INTERSECT: begin
                for (int i = 0; i < n && hit < 0; i++) begin
                    if (f == FUNC_CONTAIN ? covers(tbl_start[rk][i], tbl_len[rk][i], qs, ql)
                                          : meets(tbl_start[rk][i], tbl_len[rk][i], qs, ql))
                        hit = i;
                end
                if (hit >= 0) r = stored_reply(ST_OK, rk, hit);
            end
            FUNC_INSERT: begin
                for (int i = 0; i < n && hit < 0; i++) begin
                    if (covers(tbl_start[rk][i], tbl_len[rk][i], qs, ql) ||
                        meets(tbl_start[rk][i], tbl_len[rk][i], qs, ql))
                        hit = i;
                end
                if (hit >= 0) begin
                    r = stored_reply(ST_OVERLAP, rk, hit);
                end else if (n >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_start[rk][n] = qs;
                    tbl_len[rk][n]   = ql;
                    tbl_tag[rk][n]   = tg;
                    tbl_count[rk]    = n + 1;
                    r = stored_reply(ST_OK, rk, n);
                end
            end
            FUNC_DELETE: begin
                for (int i = 0; i < n && hit < 0; i++)
                    if (tbl_start[rk][i] == qs) hit = i;
                if (hit >= 0) begin
                    r = stored_reply(ST_OK, rk, hit);
                    // close the gap, keeping insertion order
                    for (int i = hit; i + 1 < n; i++) begin
                        tbl_start[rk][i] = tbl_start[rk][i+1];
                        tbl_len[rk][i]   = tbl_len[rk][i+1];
                        tbl_tag[rk][i]   = tbl_tag[rk][i+1];
                    end
                    tbl_count[rk] = n - 1;
                end
            end
        endcase
        return r;
    endfunction

    // Offer one command, with a random gap first outside the steady stream, and record its reply
    task automatic send_op(func_t f, logic [3:0] rk, logic [47:0] qs,
                           logic [47:0] ql, logic [31:0] tg);
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, tg, ql, qs, rk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_replies.push_back(apply_region_op(f, rk, qs, ql, tg));
        ops_sent[f]++;
    endtask

    // Withdraw the offer and hold until every reply has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_addr();
        logic [63:0] raw;
        int sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 15);
        if (sel < 2) return raw[47:0];
        if (sel == 2) return 48'hFFFF_FFFF_F000 + raw[11:0];
        return {30'b0, raw[37:32], raw[11:0]};
    endfunction

    function automatic logic [47:0] rand_len();
        logic [63:0] raw;
        int sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 15);
        if (sel < 2) return '0;
        if (sel == 2) return raw[47:0];
        return {35'b0, raw[12:0]} + 48'd1;
    endfunction

    task automatic test_directed_edges();
        // address zero and the top of the space with the largest length
        send_op(FUNC_INSERT,    4'd0, 48'h0, 48'h10, 32'h0);
        send_op(FUNC_INSERT,    4'd0, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_CONTAIN,   4'd0, 48'h4, 48'h4, 32'h0);
        send_op(FUNC_CONTAIN,   4'd0, 48'hC, 48'h8, 32'h0);
        send_op(FUNC_INTERSECT, 4'd0, 48'hC, 48'h8, 32'h0);
        send_op(FUNC_INTERSECT, 4'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
        // empty query just past the end of a region
        send_op(FUNC_CONTAIN,   4'd0, 48'h10, 48'h0, 32'h0);
        send_op(FUNC_INTERSECT, 4'd0, 48'h10, 48'h0, 32'h0);
        send_op(FUNC_INSERT,    4'd0, 48'h8, 48'h4, 32'h1111_1111);
        send_op(FUNC_INSERT,    4'd0, 48'h10, 48'h0, 32'h2222_2222);
        send_op(FUNC_INSERT,    4'd0, 48'h20, 48'h20, 32'hA5A5_A5A5);
        send_op(FUNC_DELETE,    4'd0, 48'h4, 48'h0, 32'h0);
        send_op(FUNC_DELETE,    4'd0, 48'h0, 48'h0, 32'h0);
        send_op(FUNC_CONTAIN,   4'd0, 48'h20, 48'h20, 32'h0);
        send_op(FUNC_INSERT,    4'd15, 48'h1234_5678_9ABC, 48'h1, 32'h5A5A_5A5A);
        send_op(FUNC_DELETE,    4'd15, 48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_DELETE,    4'd15, 48'h1234_5678_9ABC, 48'h0, 32'h0);
        send_op(FUNC_CONTAIN,   4'd15, 48'h0, 48'hFFFF_FFFF_FFFF, 32'h0);
        // zero-length region
        send_op(FUNC_INSERT,    4'd15, 48'h100, 48'h0, 32'h0000_FFFF);
        send_op(FUNC_CONTAIN,   4'd15, 48'h100, 48'h0, 32'h0);
        send_op(FUNC_INTERSECT, 4'd15, 48'h100, 48'h1, 32'h0);
        send_op(FUNC_DELETE,    4'd15, 48'h100, 48'h0, 32'h0);
        // several regions match: first in table order wins
        send_op(FUNC_INTERSECT, 4'd0, 48'h0, 48'hFFFF_FFFF_FFFF, 32'h0);
    endtask

    task automatic test_fill_rank();
        logic [47:0] base_addr [SLOTS];
        for (int i = 0; i < SLOTS; i++) begin
            base_addr[i] = 48'h7000_0000 + i * 48'h1000 + $urandom_range(0, 'h7FF);
            send_op(FUNC_INSERT, 4'd7, base_addr[i], 48'($urandom_range(1, 'h7FF)), $urandom);
        end
        send_op(FUNC_INSERT,    4'd7, 48'h7100_0000, 48'h10, $urandom);
        // a conflict is reported ahead of a full table
        send_op(FUNC_INSERT,    4'd7, base_addr[3], 48'h1, $urandom);
        send_op(FUNC_DELETE,    4'd7, base_addr[5], 48'h0, 32'h0);
        send_op(FUNC_CONTAIN,   4'd7, base_addr[15], 48'h1, 32'h0);
        send_op(FUNC_DELETE,    4'd7, base_addr[15], 48'h0, 32'h0);
        send_op(FUNC_DELETE,    4'd7, base_addr[0], 48'h0, 32'h0);
        send_op(FUNC_INTERSECT, 4'd7, 48'h7000_0000, 48'h10000, 32'h0);
    endtask

    task automatic test_random_ops(int n_items);
        func_t       f;
        logic [3:0]  rk;
        logic [47:0] qs;
        logic [47:0] ql;
        logic [31:0] tg;
        logic [63:0] span;
        logic [63:0] off;
        logic [63:0] raw;
        int          pick;
        int          i;
        for (int k = 0; k < n_items; k++) begin
            rk   = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            f    = func_t'(pick < 40 ? FUNC_INSERT : pick < 65 ? FUNC_DELETE :
                           pick < 85 ? FUNC_CONTAIN : FUNC_INTERSECT);
            qs   = rand_addr();
            ql   = rand_len();
            tg   = $urandom;
            if (tbl_count[rk] > 0) begin
                i    = $urandom_range(0, tbl_count[rk] - 1);
                span = {16'b0, tbl_len[rk][i]};
                case (f)
                    FUNC_CONTAIN, FUNC_INTERSECT: begin
                        // aim most queries into or around a stored region
                        if ($urandom_range(0, 2) != 0) begin
                            off = {$urandom, $urandom} % (span + 64'd1);
                            qs  = tbl_start[rk][i] + off[47:0];
                            raw = {$urandom, $urandom} % (span - off + 64'd2);
                            ql  = raw[47:0];
                        end
                    end
                    FUNC_INSERT: begin
                        if ($urandom_range(0, 4) == 0)
                            qs = tbl_start[rk][i] + 48'($urandom_range(0, 'hFFF));
                    end
                    FUNC_DELETE: begin
                        if ($urandom_range(0, 3) != 0) qs = tbl_start[rk][i];
                    end
                endcase
            end
            send_op(f, rk, qs, ql, tg);
        end
    endtask

    task automatic test_steady_stream(int n_items);
        steady <= 1'b1;
        test_random_ops(n_items);
        steady <= 1'b0;
    endtask

    // Hold the result side off while commands keep coming, then drain
    task automatic test_backpressure();
        rx_hold <= 300;
        test_random_ops(40);
        wait_drain();
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 99) >= 23;
        end
    end

    always @(posedge aclk) begin
        region_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                status_seen[want.status]++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[M_START_LSB +: FIELD_W] !== want.start) begin
                    $error("hit_start: expected %h, got %h", want.start,
                           m_tdata[M_START_LSB +: FIELD_W]);
                    mismatches++;
                end
                if (m_tdata[M_LEN_LSB +: FIELD_W] !== want.len) begin
                    $error("hit_length: expected %h, got %h", want.len,
                           m_tdata[M_LEN_LSB +: FIELD_W]);
                    mismatches++;
                end
                if (m_tdata[M_TAG_LSB +: TAG_W] !== want.tag) begin
                    $error("hit_tag: expected %h, got %h", want.tag,
                           m_tdata[M_TAG_LSB +: TAG_W]);
                    mismatches++;
                end
                if (m_tdata[M_SLOT_LSB +: SLOT_W] !== want.slot) begin
                    $error("hit_slot: expected %0d, got %0d", want.slot,
                           m_tdata[M_SLOT_LSB +: SLOT_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < RANKS; r++) tbl_count[r] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_fill_rank();
        test_random_ops(350);
        test_steady_stream(150);
        test_backpressure();
        test_random_ops(560);

        s_tvalid <= 1'b0;
        wait_drain();
        repeat (40) @(posedge aclk);

        $display("Sent %0d contain, %0d intersect, %0d insert and %0d delete commands",
                 ops_sent[FUNC_CONTAIN], ops_sent[FUNC_INTERSECT],
                 ops_sent[FUNC_INSERT], ops_sent[FUNC_DELETE]);
        $display("Replies: %0d ok, %0d miss, %0d overlap, %0d full",
                 status_seen[ST_OK], status_seen[ST_MISS],
                 status_seen[ST_OVERLAP], status_seen[ST_FULL]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
